// ===== rtl/hsc_pkg.sv =====
// hsc_pkg: shared constants, codes and types of the humidity compensation block
// no dependencies; compile first

package hsc_pkg;

  // internal fixed point fraction bits of the humidity polynomial (range 24..48)
  localparam int unsigned FRACTION_BITS = 32;

  localparam int unsigned RAW_T_W    = 20;
  localparam int unsigned RAW_H_W    = 16;
  localparam int unsigned HUM_W      = 17;
  localparam int unsigned TFINE_W    = 21;
  localparam int unsigned CLAMP_W    = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [HUM_W-1:0] HUM_MAX = 17'd102400;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_T1  = 3'd0,
    REG_T2  = 3'd1,
    REG_T3  = 3'd2,
    REG_H13 = 3'd3,
    REG_H2  = 3'd4,
    REG_H4  = 3'd5,
    REG_H5  = 3'd6,
    REG_H6  = 3'd7
  } cfg_reg_e;

  typedef enum logic [CLAMP_W-1:0] {
    CLAMP_NONE = 2'd0,
    CLAMP_HIGH = 2'd1,
    CLAMP_LOW  = 2'd2
  } clamp_e;

  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [7:0]  h1;
    logic        [7:0]  h3;
    logic signed [15:0] h2;
    logic signed [11:0] h4;
    logic signed [11:0] h5;
    logic signed [7:0]  h6;
  } hsc_coeff_t;

endpackage

// ===== rtl/hsc_intf.sv =====
// hsc_intf: valid/ready channel interfaces of the humidity compensation block
// depends on hsc_pkg for field widths

interface hsc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [hsc_pkg::CFG_IDX_W-1:0]    index;
  logic [hsc_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface hsc_in_if;
  logic                          valid;
  logic                          ready;
  logic [hsc_pkg::RAW_T_W-1:0]   raw_temperature;
  logic [hsc_pkg::RAW_H_W-1:0]   raw_humidity;

  modport source (output valid, raw_temperature, raw_humidity, input ready);
  modport sink   (input valid, raw_temperature, raw_humidity, output ready);
endinterface

interface hsc_out_if;
  logic                                valid;
  logic                                ready;
  logic        [hsc_pkg::HUM_W-1:0]    humidity;
  logic signed [hsc_pkg::TFINE_W-1:0]  fine_temperature;
  logic        [hsc_pkg::CLAMP_W-1:0]  clamp_status;

  modport source (output valid, humidity, fine_temperature, clamp_status, input ready);
  modport sink   (input valid, humidity, fine_temperature, clamp_status, output ready);
endinterface

// ===== rtl/hsc_cfg_regs.sv =====
// hsc_cfg_regs: calibration coefficient registers written over the config channel
// depends on hsc_pkg and hsc_intf

module hsc_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  hsc_cfg_if.sink             cfg_i,
  output hsc_pkg::hsc_coeff_t coeff_o
);
  import hsc_pkg::*;

  hsc_coeff_t coeff_q, coeff_d;
  logic       wr_en;

  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid & cfg_i.ready;

  always_comb begin
    coeff_d = coeff_q;
    if (wr_en) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_T1:  coeff_d.t1 = cfg_i.data;
        REG_T2:  coeff_d.t2 = $signed(cfg_i.data);
        REG_T3:  coeff_d.t3 = $signed(cfg_i.data);
        REG_H13: begin
          coeff_d.h1 = cfg_i.data[7:0];
          coeff_d.h3 = cfg_i.data[15:8];
        end
        REG_H2:  coeff_d.h2 = $signed(cfg_i.data);
        REG_H4:  coeff_d.h4 = $signed(cfg_i.data[11:0]);
        REG_H5:  coeff_d.h5 = $signed(cfg_i.data[11:0]);
        REG_H6:  coeff_d.h6 = $signed(cfg_i.data[7:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q <= '0;
    end else begin
      coeff_q <= coeff_d;
    end
  end

  assign coeff_o = coeff_q;

endmodule

// ===== rtl/humidity_sensor_compensation_top.sv =====
// humidity_sensor_compensation_top: fine temperature and humidity compensation pipeline
// depends on hsc_pkg, hsc_intf and hsc_cfg_regs
//
// Usage:
//   cfg_i  - calibration writes (index 0..7, 16-bit data), always ready. Write the
//            coefficients while no reading is in flight; reset clears them to zero.
//   in_i   - one raw temperature / raw humidity pair per transfer.
//   out_o  - humidity in 1/1024 percent, fine temperature and clamp status.
//   The datapath is 13 register stages: fine temperature (3 stages), polynomial
//   terms (3), humidity gain product (2), curvature correction (4) and the output
//   register. Throughput is one reading per cycle while out_o.ready is high; every
//   multiply is split so that no stage holds more than one multiplier depth, which
//   sets the stage count.
//   Each stage carries a valid bit and advances when its successor is empty or
//   advancing, so bubbles close up while out_o stalls. in_i.ready drops only once
//   all 13 stages hold readings and out_o.ready is low; nothing is lost or repeated.
//   Reset clears all stage valid bits and the coefficient registers.

module humidity_sensor_compensation_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  hsc_cfg_if.sink   cfg_i,
  hsc_in_if.sink    in_i,
  hsc_out_if.source out_o
);
  import hsc_pkg::*;

  localparam int unsigned NS   = 13;
  localparam int unsigned F    = FRACTION_BITS;
  localparam int unsigned A14W = 34;
  localparam int unsigned CNW  = 60;
  localparam int unsigned GPW  = CNW + 16;
  localparam int unsigned GW   = F + 8;
  localparam int unsigned GSH  = GPW - GW;
  localparam int unsigned GLO  = GW / 2;
  localparam int unsigned GHI  = GW - GLO;
  localparam int unsigned PLW  = A14W + GLO + 1;
  localparam int unsigned PHW  = A14W + GHI;
  localparam int unsigned HPW  = A14W + GW;
  localparam int unsigned H1W  = HPW - 14;
  localparam int unsigned HUW  = F + 20;
  localparam int unsigned TW   = F + 8;
  localparam int unsigned HLO  = HUW / 2;
  localparam int unsigned HHI  = HUW - HLO;
  localparam int unsigned TLO  = TW / 2;
  localparam int unsigned THI  = TW - TLO;
  localparam int unsigned PW   = HUW + TW;
  localparam int unsigned QW   = PW - F;
  localparam int unsigned HW   = QW + 1;

  localparam logic signed [23:0]      TSUM_MAX  = 24'sd1048575;
  localparam logic signed [23:0]      TSUM_MIN  = -24'sd1048576;
  localparam logic signed [21:0]      TF_OFFS   = 22'sd76800;
  localparam logic signed [29:0]      H3_BIAS   = 30'sd67108864;
  localparam logic signed [CNW-1:0]   CN_BIAS   = CNW'(1) <<< 52;
  localparam logic signed [H1W-1:0]   H1_LIMIT  = H1W'(1) <<< (19 + F);
  localparam logic        [PW-1:0]    ROUND_UP  = (PW'(1) << F) - PW'(1);
  localparam logic signed [HW-1:0]    HUNDRED   = HW'(100) <<< F;
  localparam logic signed [HW-1:0]    HALF_LSB  = HW'(1) <<< (F - 11);

  hsc_coeff_t coeff;

  hsc_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_i),
    .coeff_o (coeff)
  );

  // ---------------------------------------------------------------- control
  logic [NS:1] vld_q, vld_d, prv, en, ld;

  assign prv = {vld_q[NS-1:1], in_i.valid};

  for (genvar k = 1; k <= NS; k++) begin : g_en
    assign en[k] = out_o.ready | ~(&vld_q[NS:k]);
  end

  assign ld    = en & prv;
  assign vld_d = (en & prv) | (~en & vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_i.ready  = en[1];
  assign out_o.valid = vld_q[NS];

  // ---------------------------------------------------------------- stage 1
  logic signed [17:0] diff1;
  logic signed [16:0] dtemp;
  logic signed [33:0] s1_p1_d, s1_p1_q, s1_dsq_full;
  logic        [31:0] s1_dsq_q;
  logic        [15:0] s1_adch_q;

  always_comb begin
    diff1       = $signed({1'b0, in_i.raw_temperature[19:3]}) - $signed({1'b0, coeff.t1, 1'b0});
    dtemp       = $signed({1'b0, in_i.raw_temperature[19:4]}) - $signed({1'b0, coeff.t1});
    s1_p1_d     = 34'(diff1) * 34'(coeff.t2);
    s1_dsq_full = 34'(dtemp) * 34'(dtemp);
  end

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      s1_p1_q   <= s1_p1_d;
      s1_dsq_q  <= s1_dsq_full[31:0];
      s1_adch_q <= in_i.raw_humidity;
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic signed [36:0] s2_var2p_d, s2_var2p_q;
  logic signed [22:0] s2_var1_q;
  logic        [15:0] s2_adch_q;

  assign s2_var2p_d = 37'($signed({1'b0, s1_dsq_q[31:12]})) * 37'(coeff.t3);

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      s2_var1_q  <= $signed(s1_p1_q[33:11]);
      s2_var2p_q <= s2_var2p_d;
      s2_adch_q  <= s1_adch_q;
    end
  end

  // ---------------------------------------------------------------- stage 3
  logic signed [23:0]        tsum;
  logic signed [TFINE_W-1:0] s3_tf_d, s3_tf_q;
  logic        [15:0]        s3_adch_q;

  always_comb begin
    tsum = 24'(s2_var1_q) + 24'($signed(s2_var2p_q[36:14]));
    if (tsum > TSUM_MAX) begin
      s3_tf_d = TSUM_MAX[TFINE_W-1:0];
    end else if (tsum < TSUM_MIN) begin
      s3_tf_d = TSUM_MIN[TFINE_W-1:0];
    end else begin
      s3_tf_d = tsum[TFINE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      s3_tf_q   <= s3_tf_d;
      s3_adch_q <= s2_adch_q;
    end
  end

  // ---------------------------------------------------------------- stage 4
  logic signed [21:0]       tv;
  logic signed [A14W-1:0]   h5v, s4_a14_d, s4_a14_q;
  logic signed [29:0]       s4_h3p_d, s4_h3p_q, s4_h6v_d, s4_h6v_q;
  logic signed [TFINE_W-1:0] s4_tf_q;

  always_comb begin
    tv       = 22'(s3_tf_q) - TF_OFFS;
    h5v      = 34'(tv) * 34'(coeff.h5);
    s4_a14_d = $signed({4'd0, s3_adch_q, 14'd0}) - 34'($signed({coeff.h4, 20'd0})) - h5v;
    s4_h3p_d = H3_BIAS + 30'($signed({1'b0, coeff.h3})) * 30'(tv);
    s4_h6v_d = 30'(coeff.h6) * 30'(tv);
  end

  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      s4_a14_q <= s4_a14_d;
      s4_h3p_q <= s4_h3p_d;
      s4_h6v_q <= s4_h6v_d;
      s4_tf_q  <= s3_tf_q;
    end
  end

  // ---------------------------------------------------------------- stage 5
  logic signed [CNW-1:0]     s5_cnp_d, s5_cnp_q;
  logic signed [A14W-1:0]    s5_a14_q;
  logic signed [TFINE_W-1:0] s5_tf_q;

  assign s5_cnp_d = CNW'(s4_h6v_q) * CNW'(s4_h3p_q);

  always_ff @(posedge clk_i) begin
    if (ld[5]) begin
      s5_cnp_q <= s5_cnp_d;
      s5_a14_q <= s4_a14_q;
      s5_tf_q  <= s4_tf_q;
    end
  end

  // ---------------------------------------------------------------- stage 6
  logic signed [CNW-1:0]     cn;
  logic signed [GPW-1:0]     s6_gp_d, s6_gp_q;
  logic signed [A14W-1:0]    s6_a14_q;
  logic signed [TFINE_W-1:0] s6_tf_q;

  always_comb begin
    cn      = s5_cnp_q + CN_BIAS;
    s6_gp_d = GPW'(cn) * GPW'(coeff.h2);
  end

  always_ff @(posedge clk_i) begin
    if (ld[6]) begin
      s6_gp_q  <= s6_gp_d;
      s6_a14_q <= s5_a14_q;
      s6_tf_q  <= s5_tf_q;
    end
  end

  // ---------------------------------------------------------------- stage 7
  // gain times offset term, split over the two halves of the gain
  logic        [GW-1:0]      gval;
  logic signed [PLW-1:0]     s7_pl_d, s7_pl_q;
  logic signed [PHW-1:0]     s7_ph_d, s7_ph_q;
  logic signed [TFINE_W-1:0] s7_tf_q;

  always_comb begin
    gval    = s6_gp_q[GSH +: GW];
    s7_pl_d = PLW'(s6_a14_q) * PLW'($signed({1'b0, gval[GLO-1:0]}));
    s7_ph_d = PHW'(s6_a14_q) * PHW'($signed(gval[GW-1:GLO]));
  end

  always_ff @(posedge clk_i) begin
    if (ld[7]) begin
      s7_pl_q <= s7_pl_d;
      s7_ph_q <= s7_ph_d;
      s7_tf_q <= s6_tf_q;
    end
  end

  // ---------------------------------------------------------------- stage 8
  logic signed [HPW-1:0]     hp;
  logic signed [TFINE_W-1:0] s8_tf_q;
  logic signed [H1W-1:0]     s8_h1_q;

  assign hp = (HPW'(s7_ph_q) <<< GLO) + HPW'(s7_pl_q);

  always_ff @(posedge clk_i) begin
    if (ld[8]) begin
      s8_h1_q <= $signed(hp[HPW-1:14]);
      s8_tf_q <= s7_tf_q;
    end
  end

  // ---------------------------------------------------------------- stage 9
  logic        [HUW+7:0]     t_full;
  logic                      s9_neg_d, s9_neg_q, s9_zero_q;
  logic        [TW-1:0]      s9_t_q;
  logic signed [H1W-1:0]     s9_h1_q;
  logic signed [TFINE_W-1:0] s9_tf_q;

  always_comb begin
    t_full   = (HUW + 8)'(s8_h1_q[HUW-1:0]) * (HUW + 8)'(coeff.h1);
    // negative, or beyond the curvature range with a nonzero coefficient
    s9_neg_d = s8_h1_q[H1W-1] | ((coeff.h1 != 8'd0) & (s8_h1_q > H1_LIMIT));
  end

  always_ff @(posedge clk_i) begin
    if (ld[9]) begin
      s9_neg_q  <= s9_neg_d;
      s9_zero_q <= (coeff.h1 == 8'd0);
      s9_t_q    <= t_full[19 +: TW];
      s9_h1_q   <= s8_h1_q;
      s9_tf_q   <= s8_tf_q;
    end
  end

  // ---------------------------------------------------------------- stage 10
  logic [HUW-1:0]            h1u;
  logic [HLO+TLO-1:0]        s10_ll_q;
  logic [HLO+THI-1:0]        s10_lh_q;
  logic [HHI+TLO-1:0]        s10_hl_q;
  logic [HHI+THI-1:0]        s10_hh_q;
  logic                      s10_neg_q, s10_zero_q;
  logic signed [H1W-1:0]     s10_h1_q;
  logic signed [TFINE_W-1:0] s10_tf_q;

  assign h1u = s9_h1_q[HUW-1:0];

  always_ff @(posedge clk_i) begin
    if (ld[10]) begin
      s10_ll_q   <= (HLO + TLO)'(h1u[HLO-1:0]) * (HLO + TLO)'(s9_t_q[TLO-1:0]);
      s10_lh_q   <= (HLO + THI)'(h1u[HLO-1:0]) * (HLO + THI)'(s9_t_q[TW-1:TLO]);
      s10_hl_q   <= (HHI + TLO)'(h1u[HUW-1:HLO]) * (HHI + TLO)'(s9_t_q[TLO-1:0]);
      s10_hh_q   <= (HHI + THI)'(h1u[HUW-1:HLO]) * (HHI + THI)'(s9_t_q[TW-1:TLO]);
      s10_neg_q  <= s9_neg_q;
      s10_zero_q <= s9_zero_q;
      s10_h1_q   <= s9_h1_q;
      s10_tf_q   <= s9_tf_q;
    end
  end

  // ---------------------------------------------------------------- stage 11
  // ceiling of h1 * t / 2^F, so that h = h1 - ceil(...) equals floor(h1 * (1 - t))
  logic [PW-1:0]             prod;
  logic [QW-1:0]             s11_q_q;
  logic                      s11_neg_q, s11_zero_q;
  logic signed [H1W-1:0]     s11_h1_q;
  logic signed [TFINE_W-1:0] s11_tf_q;

  assign prod = (PW'(s10_hh_q) << (HLO + TLO)) + (PW'(s10_hl_q) << HLO)
              + (PW'(s10_lh_q) << TLO) + PW'(s10_ll_q) + ROUND_UP;

  always_ff @(posedge clk_i) begin
    if (ld[11]) begin
      s11_q_q    <= prod[PW-1:F];
      s11_neg_q  <= s10_neg_q;
      s11_zero_q <= s10_zero_q;
      s11_h1_q   <= s10_h1_q;
      s11_tf_q   <= s10_tf_q;
    end
  end

  // ---------------------------------------------------------------- stage 12
  logic signed [HW-1:0]      s12_h_d, s12_h_q;
  logic signed [TFINE_W-1:0] s12_tf_q;

  always_comb begin
    if (s11_neg_q) begin
      s12_h_d = -HW'(1);
    end else if (s11_zero_q) begin
      s12_h_d = HW'(s11_h1_q);
    end else begin
      s12_h_d = HW'($signed({1'b0, s11_h1_q[HUW-1:0]})) - $signed({1'b0, s11_q_q});
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[12]) begin
      s12_h_q  <= s12_h_d;
      s12_tf_q <= s11_tf_q;
    end
  end

  // ---------------------------------------------------------------- stage 13 (output)
  logic signed [HW-1:0]      hround;
  logic        [HUM_W-1:0]   out_hum_d, out_hum_q;
  clamp_e                    out_clamp_d, out_clamp_q;
  logic signed [TFINE_W-1:0] out_tf_q;

  always_comb begin
    hround = s12_h_q + HALF_LSB;
    if (s12_h_q > HUNDRED) begin
      out_hum_d   = HUM_MAX;
      out_clamp_d = CLAMP_HIGH;
    end else if (s12_h_q[HW-1]) begin
      out_hum_d   = '0;
      out_clamp_d = CLAMP_LOW;
    end else begin
      out_hum_d   = hround[(F - 10) +: HUM_W];
      out_clamp_d = CLAMP_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[13]) begin
      out_hum_q   <= out_hum_d;
      out_clamp_q <= out_clamp_d;
      out_tf_q    <= s12_tf_q;
    end
  end

  assign out_o.humidity         = out_hum_q;
  assign out_o.fine_temperature = out_tf_q;
  assign out_o.clamp_status     = out_clamp_q;

  // ---------------------------------------------------------------- assertions
  logic in_xfer, out_xfer;

  assign in_xfer  = in_i.valid & in_i.ready;
  assign out_xfer = out_o.valid & out_o.ready;

  // input back-pressure only when every stage is occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (&vld_q))
    else $error("input stalled with an empty stage");

  // occupancy follows the transfers on both sides
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rst_ni |=> $countones(vld_q) ==
      $past($countones(vld_q)) + int'($past(in_xfer)) - int'($past(out_xfer)))
    else $error("pipeline occupancy does not match transfers");

  // an upper clamp always reports full scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.clamp_status == CLAMP_HIGH) |-> (out_o.humidity == HUM_MAX))
    else $error("upper clamp without full-scale humidity");

endmodule

// ===== dv/humidity_sensor_compensation_top_test.sv =====
// humidity_sensor_compensation_top_test: self-checking bench for the humidity compensation top
// drives calibration writes and raw readings, predicts every result and checks it in order
// depends on hsc_pkg, hsc_intf and the rtl of humidity_sensor_compensation_top
`timescale 1ns / 100ps

module humidity_sensor_compensation_top_test;
  import hsc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned PIPE_SETTLE  = 20;

  typedef struct {
    logic [RAW_T_W-1:0] raw_temperature;
    logic [RAW_H_W-1:0] raw_humidity;
  } reading_t;

  typedef struct {
    logic        [HUM_W-1:0]   humidity;
    logic signed [TFINE_W-1:0] fine_temperature;
    clamp_e                    clamp_status;
  } hum_result_t;

  typedef enum {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  hsc_cfg_if cfg_if ();
  hsc_in_if  in_if ();
  hsc_out_if out_if ();

  humidity_sensor_compensation_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  reading_t    reading_q[$];
  hum_result_t hum_expect_q[$];
  hsc_coeff_t  coeff_shadow = '0;

  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  bit          hold_go       = 1'b0;
  bit          sink_blocked  = 1'b0;
  int unsigned in_accepts    = 0;
  int unsigned offer_mark    = 0;
  int unsigned errors        = 0;
  int unsigned results_checked = 0;
  int unsigned clamp_hi      = 0;
  int unsigned clamp_lo      = 0;
  int unsigned stall_cycles  = 0;
  int unsigned config_sets   = 0;
  int unsigned cycle_count   = 0;

  // fine temperature, then humidity polynomial in exact fixed point
  function automatic hum_result_t predict_humidity(reading_t rd);
    longint adc_t, adc_h, t1, t2, t3, h1c, h3c, h2c, h4c, h5c, h6c;
    longint var1, var2, dt, tf, v, a14, cn, g, t, fac;
    logic signed [127:0] wide, h1w, hw, limit;
    hum_result_t r;
    adc_t = rd.raw_temperature;
    adc_h = rd.raw_humidity;
    t1  = coeff_shadow.t1;
    t2  = signed'(coeff_shadow.t2);
    t3  = signed'(coeff_shadow.t3);
    h1c = coeff_shadow.h1;
    h3c = coeff_shadow.h3;
    h2c = signed'(coeff_shadow.h2);
    h4c = signed'(coeff_shadow.h4);
    h5c = signed'(coeff_shadow.h5);
    h6c = signed'(coeff_shadow.h6);

    var1 = (((adc_t >>> 3) - 2 * t1) * t2) >>> 11;
    dt   = (adc_t >>> 4) - t1;
    var2 = (((dt * dt) >>> 12) * t3) >>> 14;
    tf   = var1 + var2;
    if (tf > 1048575) tf = 1048575;
    if (tf < -1048576) tf = -1048576;

    v   = tf - 76800;
    a14 = adc_h * 16384 - h4c * 1048576 - h5c * v;
    cn  = (longint'(1) <<< 52) + h6c * v * ((longint'(1) <<< 26) + h3c * v);
    wide = cn;
    wide = (wide * h2c) >>> (68 - FRACTION_BITS);
    g    = wide[63:0];
    h1w  = g;
    h1w  = (h1w * a14) >>> 14;

    limit = 1;
    limit = limit <<< (19 + FRACTION_BITS);
    if (h1w < 0) begin
      hw = -1;
    end else if (h1c == 0) begin
      hw = h1w;
    end else if (h1w > limit) begin
      hw = -1;
    end else begin
      wide = (h1w * h1c) >>> 19;
      t    = wide[63:0];
      fac  = (longint'(1) <<< FRACTION_BITS) - t;
      hw   = (h1w * fac) >>> FRACTION_BITS;
    end

    limit = 100;
    limit = limit <<< FRACTION_BITS;
    if (hw > limit) begin
      r.humidity     = HUM_MAX;
      r.clamp_status = CLAMP_HIGH;
    end else if (hw < 0) begin
      r.humidity     = '0;
      r.clamp_status = CLAMP_LOW;
    end else begin
      limit = 1;
      wide  = (hw + (limit <<< (FRACTION_BITS - 11))) >>> (FRACTION_BITS - 10);
      r.humidity     = wide[HUM_W-1:0];
      r.clamp_status = CLAMP_NONE;
    end
    r.fine_temperature = tf[TFINE_W-1:0];
    return r;
  endfunction

  // input side: hold an offered reading until its transfer, idle only between readings
  always @(negedge clk_i) begin : reading_driver
    if (!in_if.valid || in_accepts != offer_mark) begin
      if (reading_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        in_if.valid           <= 1'b1;
        in_if.raw_temperature <= reading_q[0].raw_temperature;
        in_if.raw_humidity    <= reading_q[0].raw_humidity;
        offer_mark            <= in_accepts;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : result_sink
    out_if.ready <= !sink_blocked && ($urandom_range(99) >= snk_stall_pct);
  end

  // long receiver hold-off so the pipeline fills and backs up into the input
  initial begin : sink_hold
    wait (hold_go);
    @(posedge clk_i);
    sink_blocked = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    sink_blocked = 1'b0;
  end

  always @(posedge clk_i) begin : scoreboard
    reading_t    rd;
    hum_result_t want;
    if (rst_ni) begin
      if (in_if.valid && !in_if.ready) stall_cycles++;
      if (in_if.valid && in_if.ready) begin
        rd = reading_q.pop_front();
        hum_expect_q.push_back(predict_humidity(rd));
        in_accepts++;
      end
      if (out_if.valid && out_if.ready) begin
        if (hum_expect_q.size() == 0) begin
          errors++;
          $display("%0t: result with none pending: expected none, got humidity %0d fine %0d status %0d",
                   $time, out_if.humidity, out_if.fine_temperature, out_if.clamp_status);
        end else begin
          want = hum_expect_q.pop_front();
          results_checked++;
          if (out_if.humidity !== want.humidity) begin
            errors++;
            $display("%0t: humidity mismatch: expected %0d, got %0d",
                     $time, want.humidity, out_if.humidity);
          end
          if (out_if.fine_temperature !== want.fine_temperature) begin
            errors++;
            $display("%0t: fine temperature mismatch: expected %0d, got %0d",
                     $time, want.fine_temperature, out_if.fine_temperature);
          end
          if (out_if.clamp_status !== want.clamp_status) begin
            errors++;
            $display("%0t: clamp status mismatch: expected %0d, got %0d",
                     $time, want.clamp_status, out_if.clamp_status);
          end
          case (want.clamp_status)
            CLAMP_HIGH: clamp_hi++;
            CLAMP_LOW:  clamp_lo++;
            default: ;
          endcase
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: timeout with %0d readings unsent and %0d results outstanding",
             $time, reading_q.size(), hum_expect_q.size());
    $display("Some tests failed");
    $finish;
  end

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      REG_T1:  coeff_shadow.t1 = value;
      REG_T2:  coeff_shadow.t2 = value;
      REG_T3:  coeff_shadow.t3 = value;
      REG_H13: begin
        coeff_shadow.h1 = value[7:0];
        coeff_shadow.h3 = value[15:8];
      end
      REG_H2:  coeff_shadow.h2 = value;
      REG_H4:  coeff_shadow.h4 = value[11:0];
      REG_H5:  coeff_shadow.h5 = value[11:0];
      REG_H6:  coeff_shadow.h6 = value[7:0];
      default: ;
    endcase
  endtask

  // junk above the used bits of the narrow coefficients must be ignored
  task automatic program_coeffs(hsc_coeff_t c);
    write_reg(REG_T1, c.t1);
    write_reg(REG_T2, c.t2);
    write_reg(REG_T3, c.t3);
    write_reg(REG_H13, {c.h3, c.h1});
    write_reg(REG_H2, c.h2);
    write_reg(REG_H4, {4'($urandom()), c.h4});
    write_reg(REG_H5, {4'($urandom()), c.h5});
    write_reg(REG_H6, {8'($urandom()), c.h6});
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    config_sets++;
  endtask

  task automatic start_phase(idle_mode_e mode);
    @(posedge clk_i);
    case (mode)
      IDLE_SRC:  begin src_idle_pct = 60; snk_stall_pct = 0;  end
      IDLE_SNK:  begin src_idle_pct = 0;  snk_stall_pct = 60; end
      IDLE_BOTH: begin src_idle_pct = 24; snk_stall_pct = 24; end
      default:   begin src_idle_pct = 0;  snk_stall_pct = 0;  end
    endcase
  endtask

  task automatic add_reading(logic [RAW_T_W-1:0] t, logic [RAW_H_W-1:0] h);
    reading_t r;
    r.raw_temperature = t;
    r.raw_humidity    = h;
    reading_q.push_back(r);
  endtask

  task automatic add_corners();
    add_reading('0, '0);
    add_reading('0, '1);
    add_reading('1, '0);
    add_reading('1, '1);
  endtask

  // with plausible set, mostly readings in the sensor's working range, the rest anywhere
  task automatic queue_readings(int unsigned n, bit plausible);
    repeat (n) begin
      if (plausible && $urandom_range(99) < 85)
        add_reading(20'($urandom_range(380000, 640000)), 16'($urandom_range(12000, 52000)));
      else
        add_reading(20'($urandom_range(20'hFFFFF)), 16'($urandom_range(16'hFFFF)));
    end
  endtask

  task automatic drain_phase();
    while (reading_q.size() != 0 || hum_expect_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_SETTLE) @(posedge clk_i);
  endtask

  initial begin : stimulus
    hsc_coeff_t c;
    rst_ni                = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = REG_T1;
    cfg_if.data           = '0;
    in_if.valid           = 1'b0;
    in_if.raw_temperature = '0;
    in_if.raw_humidity    = '0;
    out_if.ready          = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // coefficients straight out of reset: everything collapses to zero
    start_phase(IDLE_NONE);
    add_corners();
    queue_readings(40, 1'b0);
    drain_phase();

    // typical part calibration, with the receiver holding off at the start
    c = '{t1: 27504, t2: 26435, t3: -1000, h1: 75, h3: 0, h2: 362,
          h4: 313, h5: 50, h6: 30};
    program_coeffs(c);
    start_phase(IDLE_NONE);
    add_reading('0, '0);
    add_reading('1, '1);
    add_reading(20'd519888, 16'd30000);
    add_reading(20'd519888, 16'd15000);
    add_reading(20'd519888, 16'd45000);
    add_reading('1, 16'd30000);
    add_reading(20'hAAAAA, 16'h5555);
    add_reading(20'h55555, 16'hAAAA);
    hold_go = 1'b1;
    queue_readings(200, 1'b1);
    drain_phase();

    start_phase(IDLE_SRC);
    queue_readings(300, 1'b1);
    drain_phase();

    // no curvature term from h1, nonzero h3
    c.h1 = 0;
    c.h3 = 200;
    program_coeffs(c);
    start_phase(IDLE_SNK);
    queue_readings(250, 1'b1);
    drain_phase();

    // hot extremes: fine temperature saturates high, big gain overflows the h1 limit
    c = '{t1: 0, t2: 32767, t3: 32767, h1: 255, h3: 255, h2: 32767,
          h4: -2048, h5: -2048, h6: 127};
    program_coeffs(c);
    start_phase(IDLE_BOTH);
    add_corners();
    queue_readings(100, 1'b0);
    drain_phase();

    c = '{t1: 65535, t2: -32768, t3: -32768, h1: 0, h3: 0, h2: -32768,
          h4: 2047, h5: 2047, h6: -128};
    program_coeffs(c);
    start_phase(IDLE_NONE);
    add_corners();
    queue_readings(100, 1'b0);
    drain_phase();

    // cold extremes: fine temperature saturates low
    c = '{t1: 65535, t2: 32767, t3: -32768, h1: 75, h3: 0, h2: 362,
          h4: 313, h5: 50, h6: 30};
    program_coeffs(c);
    start_phase(IDLE_SRC);
    queue_readings(60, 1'b0);
    drain_phase();

    for (int k = 0; k < 7; k++) begin
      if (k < 6) begin
        c.t1 = 16'(27504 + $urandom_range(4000) - 2000);
        c.t2 = 16'(24435 + $urandom_range(4000));
        c.t3 = 16'(int'($urandom_range(1000)) - 1500);
        c.h1 = 8'($urandom_range(100));
        c.h3 = 8'($urandom_range(255));
        c.h2 = 16'(300 + $urandom_range(120));
        c.h4 = 12'(250 + $urandom_range(150));
        c.h5 = 12'(int'($urandom_range(150)) - 50);
        c.h6 = 8'(int'($urandom_range(90)) - 30);
      end else begin
        c.t1 = 16'($urandom());
        c.t2 = 16'($urandom());
        c.t3 = 16'($urandom());
        c.h1 = 8'($urandom());
        c.h3 = 8'($urandom());
        c.h2 = 16'($urandom());
        c.h4 = 12'($urandom());
        c.h5 = 12'($urandom());
        c.h6 = 8'($urandom());
      end
      program_coeffs(c);
      start_phase(idle_mode_e'(k % 4));
      queue_readings(150, 1'b1);
      drain_phase();
    end

    $display("checked %0d results from %0d readings over %0d calibration sets",
             results_checked, in_accepts, config_sets);
    $display("%0d clamped at full scale, %0d clamped at zero, input stalled for %0d cycles",
             clamp_hi, clamp_lo, stall_cycles);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
